/* hw/rtl/m4cp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4cp_pkg
// Shared types and constants of the 4x4 fixed-point column product block.
// ----------------------------------------------------------------------------
package m4cp_pkg;

   localparam int DATA_WIDTH            = 32;
   localparam int PROD_WIDTH            = 2 * DATA_WIDTH;
   localparam int PAIR_WIDTH            = PROD_WIDTH + 1;
   localparam int SUM_WIDTH             = PROD_WIDTH + 2;
   localparam int DIM                   = 4;
   localparam int FRACTION_BITS_DEFAULT = 16;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [PAIR_WIDTH-1:0] pair_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic [1:0]                   index_type;

   typedef enum logic [1:0] {
      CMD_LOAD     = 2'd0,
      CMD_MULTIPLY = 2'd1,
      CMD_POINT    = 2'd2
   } cmd_type;

   // Sideband that travels with each beat down the pipeline.
   typedef struct packed {
      index_type column;
   } tag_type;

endpackage
`default_nettype wire

/* hw/rtl/m4cp_matrix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4cp_matrix
// Holds the left matrix and registers the sixteen multiplier operand pairs
// for each multiply or point beat.
// ----------------------------------------------------------------------------
module m4cp_matrix #(
   parameter int FRACTION_BITS = m4cp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_cmd,
   input  m4cp_pkg::index_type in_column,
   input  m4cp_pkg::word_type  in_elem [m4cp_pkg::DIM],
   output logic                out_valid,
   input  logic                out_ready,
   output m4cp_pkg::tag_type   out_tag,
   output m4cp_pkg::word_type  out_a [m4cp_pkg::DIM][m4cp_pkg::DIM],
   output m4cp_pkg::word_type  out_b [m4cp_pkg::DIM][m4cp_pkg::DIM]
);
   import m4cp_pkg::*;

   localparam word_type ONE = DATA_WIDTH'(1) << FRACTION_BITS;

   word_type matrix_ff [DIM][DIM];
   word_type a_ff [DIM][DIM];
   word_type b_ff [DIM][DIM];
   word_type a_in [DIM][DIM];
   word_type b_in [DIM][DIM];
   tag_type  tag_ff;
   tag_type  tag_in;
   logic     valid_ff;
   logic     accept;
   logic     is_mul;
   logic     is_point;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign is_mul   = (in_cmd == CMD_MULTIPLY);
   assign is_point = (in_cmd == CMD_POINT);

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int k = 0; k < DIM; k++) begin
            if (is_mul) begin
               a_in[r][k] = matrix_ff[k][r];
               b_in[r][k] = in_elem[k];
            end else begin
               a_in[r][k] = (r < DIM - 1) ? matrix_ff[r][k] : '0;
               b_in[r][k] = (k < DIM - 1) ? in_elem[k] : ONE;
            end
         end
      end
      tag_in.column = is_mul ? in_column : '0;
   end

   always_ff @(posedge clock) begin
      if (accept && (in_cmd == CMD_LOAD)) begin
         for (int k = 0; k < DIM; k++) begin
            matrix_ff[in_column][k] <= in_elem[k];
         end
      end
      if (accept) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid && (is_mul || is_point);
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;

endmodule
`default_nettype wire

/* hw/rtl/m4cp_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4cp_mul
// Sixteen signed 32 by 32 multipliers with registered exact products.
// ----------------------------------------------------------------------------
module m4cp_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  m4cp_pkg::tag_type  in_tag,
   input  m4cp_pkg::word_type in_a [m4cp_pkg::DIM][m4cp_pkg::DIM],
   input  m4cp_pkg::word_type in_b [m4cp_pkg::DIM][m4cp_pkg::DIM],
   output logic               out_valid,
   input  logic               out_ready,
   output m4cp_pkg::tag_type  out_tag,
   output m4cp_pkg::prod_type out_prod [m4cp_pkg::DIM][m4cp_pkg::DIM]
);
   import m4cp_pkg::*;

   prod_type prod_ff [DIM][DIM];
   prod_type prod_in [DIM][DIM];
   tag_type  tag_ff;
   logic     valid_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int k = 0; k < DIM; k++) begin
            prod_in[r][k] = PROD_WIDTH'(in_a[r][k]) * PROD_WIDTH'(in_b[r][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
         tag_ff  <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_prod  = prod_ff;

endmodule
`default_nettype wire

/* hw/rtl/m4cp_reduce.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// m4cp_reduce
// Adds the four products of each row in two registered levels, then shifts
// out the fraction bits, saturates to 32 bits and holds the result beat.
// ----------------------------------------------------------------------------
module m4cp_reduce #(
   parameter int FRACTION_BITS = m4cp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  m4cp_pkg::tag_type  in_tag,
   input  m4cp_pkg::prod_type in_prod [m4cp_pkg::DIM][m4cp_pkg::DIM],
   output logic               out_valid,
   input  logic               out_ready,
   output m4cp_pkg::tag_type  out_tag,
   output m4cp_pkg::word_type out_res [m4cp_pkg::DIM],
   output logic               out_overflow
);
   import m4cp_pkg::*;

   pair_type pair_ff [DIM][2];
   sum_type  sum_ff [DIM];
   sum_type  shifted [DIM];
   word_type res_ff [DIM];
   word_type res_in [DIM];
   logic     row_ovf [DIM];
   logic     overflow_ff;
   logic     overflow_in;
   tag_type  pair_tag_ff;
   tag_type  sum_tag_ff;
   tag_type  res_tag_ff;
   logic     pair_valid_ff;
   logic     sum_valid_ff;
   logic     res_valid_ff;
   logic     pair_ready;
   logic     sum_ready;
   logic     res_ready;

   assign res_ready  = !res_valid_ff || out_ready;
   assign sum_ready  = !sum_valid_ff || res_ready;
   assign pair_ready = !pair_valid_ff || sum_ready;
   assign in_ready   = pair_ready;

   always_comb begin
      overflow_in = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         shifted[r] = sum_ff[r] >>> FRACTION_BITS;
         row_ovf[r] = (shifted[r][SUM_WIDTH-1:DATA_WIDTH-1] != '0)
                   && (shifted[r][SUM_WIDTH-1:DATA_WIDTH-1] != '1);
         if (row_ovf[r]) begin
            res_in[r] = shifted[r][SUM_WIDTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                                : {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end else begin
            res_in[r] = shifted[r][DATA_WIDTH-1:0];
         end
         overflow_in = overflow_in | row_ovf[r];
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && pair_ready) begin
         for (int r = 0; r < DIM; r++) begin
            pair_ff[r][0] <= PAIR_WIDTH'(in_prod[r][0]) + PAIR_WIDTH'(in_prod[r][1]);
            pair_ff[r][1] <= PAIR_WIDTH'(in_prod[r][2]) + PAIR_WIDTH'(in_prod[r][3]);
         end
         pair_tag_ff <= in_tag;
      end
      if (pair_valid_ff && sum_ready) begin
         for (int r = 0; r < DIM; r++) begin
            sum_ff[r] <= SUM_WIDTH'(pair_ff[r][0]) + SUM_WIDTH'(pair_ff[r][1]);
         end
         sum_tag_ff <= pair_tag_ff;
      end
      if (sum_valid_ff && res_ready) begin
         res_ff      <= res_in;
         overflow_ff <= overflow_in;
         res_tag_ff  <= sum_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         if (pair_ready) begin
            pair_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= pair_valid_ff;
         end
         if (res_ready) begin
            res_valid_ff <= sum_valid_ff;
         end
      end
   end

   assign out_valid    = res_valid_ff;
   assign out_tag      = res_tag_ff;
   assign out_res      = res_ff;
   assign out_overflow = overflow_ff;

endmodule
`default_nettype wire

/* hw/rtl/matrix4_column_product.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_column_product
// 4x4 signed fixed-point left matrix, loaded by columns, multiplied by right
// matrix columns or applied to x,y,z points, with saturated results.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   cmd, column_index, elem0..3
//   rsp_      out        rsp_valid/rsp_ready   res0..3, out_column, overflow
//
// A beat can enter every cycle unless the pipeline is stalled. A multiply or
// point beat reaches the result register through operand select at the accept
// edge, then multiply, two adder levels, and shift and saturate. A load
// writes its column at the accept edge and is seen by the very next beat; it
// returns no result.
// Reset clears the valid bits only; the matrix is undefined until loaded.
// Each stage holds while the next is full and stalled, so nothing is lost.
// ----------------------------------------------------------------------------
module matrix4_column_product #(
   parameter int FRACTION_BITS = m4cp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  m4cp_pkg::index_type req_column_index,
   input  m4cp_pkg::word_type  req_elem0,
   input  m4cp_pkg::word_type  req_elem1,
   input  m4cp_pkg::word_type  req_elem2,
   input  m4cp_pkg::word_type  req_elem3,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output m4cp_pkg::word_type  rsp_res0,
   output m4cp_pkg::word_type  rsp_res1,
   output m4cp_pkg::word_type  rsp_res2,
   output m4cp_pkg::word_type  rsp_res3,
   output m4cp_pkg::index_type rsp_out_column,
   output logic                rsp_overflow
);
   import m4cp_pkg::*;

   word_type elem [DIM];
   word_type op_a [DIM][DIM];
   word_type op_b [DIM][DIM];
   prod_type prod [DIM][DIM];
   word_type res  [DIM];
   tag_type  op_tag;
   tag_type  prod_tag;
   tag_type  res_tag;
   logic     op_valid;
   logic     op_ready;
   logic     prod_valid;
   logic     prod_ready;

   assign elem[0] = req_elem0;
   assign elem[1] = req_elem1;
   assign elem[2] = req_elem2;
   assign elem[3] = req_elem3;

   m4cp_matrix #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (req_cmd),
      .in_column (req_column_index),
      .in_elem   (elem),
      .out_valid (op_valid),
      .out_ready (op_ready),
      .out_tag   (op_tag),
      .out_a     (op_a),
      .out_b     (op_b)
   );

   m4cp_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (op_valid),
      .in_ready  (op_ready),
      .in_tag    (op_tag),
      .in_a      (op_a),
      .in_b      (op_b),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_tag   (prod_tag),
      .out_prod  (prod)
   );

   m4cp_reduce #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_reduce (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (prod_valid),
      .in_ready     (prod_ready),
      .in_tag       (prod_tag),
      .in_prod      (prod),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_tag      (res_tag),
      .out_res      (res),
      .out_overflow (rsp_overflow)
   );

   assign rsp_res0       = res[0];
   assign rsp_res1       = res[1];
   assign rsp_res2       = res[2];
   assign rsp_res3       = res[3];
   assign rsp_out_column = res_tag.column;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x4 fixed-point column product block.
//
// The bench loads left matrix columns, sends right matrix columns and x,y,z
// points over the request channel, and predicts every result beat with its
// own copy of the matrix. It checks each result against the oldest pending
// prediction. Directed beats hit the field extremes, saturation in both
// directions, rounding of negative sums and the unused command. Random
// phases then vary sender gaps and receiver stalls, and one long receiver
// hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
   import m4cp_pkg::*;

   localparam int      FRAC        = FRACTION_BITS_DEFAULT;
   localparam int      CYCLE_LIMIT = 200000;
   localparam int      HOLD_CYCLES = 300;
   localparam int      PRINT_LIMIT = 25;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam word_type WORD_MAX   = 32'h7fff_ffff;
   localparam word_type WORD_MIN   = 32'h8000_0000;
   localparam word_type WORD_ONE   = 32'h0001_0000;

   typedef struct {
      word_type  res [4];
      index_type column;
      logic      overflow;
   } product_beat_type;

   class column_product_scoreboard;
      word_type         left_cols [16];
      product_beat_type expected_q [$];
      int               errors;
      int               loads;
      int               products;
      int               points;
      int               ignored;

      function new();
         errors = 0;
         loads = 0;
         products = 0;
         points = 0;
         ignored = 0;
         foreach (left_cols[i]) left_cols[i] = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      endtask

      function word_type clamp_word(sum_type total, inout logic flag);
         sum_type shifted;
         shifted = total >>> FRAC;
         if (shifted > sum_type'(WORD_MAX)) begin
            flag = 1'b1;
            return WORD_MAX;
         end
         if (shifted < sum_type'(WORD_MIN)) begin
            flag = 1'b1;
            return WORD_MIN;
         end
         return word_type'(shifted);
      endfunction

      function void note_request(logic [1:0] cmd, index_type col, word_type e0,
                                 word_type e1, word_type e2, word_type e3);
         word_type         elems [4];
         product_beat_type want;
         sum_type          acc;
         elems = '{e0, e1, e2, e3};
         want.overflow = 1'b0;
         case (cmd)
            CMD_LOAD: begin
               for (int r = 0; r < 4; r++) left_cols[col * 4 + r] = elems[r];
               loads++;
            end
            CMD_MULTIPLY: begin
               for (int r = 0; r < 4; r++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++)
                     acc = acc + sum_type'(left_cols[k * 4 + r]) * sum_type'(elems[k]);
                  want.res[r] = clamp_word(acc, want.overflow);
               end
               want.column = col;
               expected_q.push_back(want);
               products++;
            end
            CMD_POINT: begin
               for (int r = 0; r < 3; r++) begin
                  acc = sum_type'(left_cols[r * 4 + 3]) <<< FRAC;
                  for (int k = 0; k < 3; k++)
                     acc = acc + sum_type'(elems[k]) * sum_type'(left_cols[r * 4 + k]);
                  want.res[r] = clamp_word(acc, want.overflow);
               end
               want.res[3] = '0;
               want.column = '0;
               expected_q.push_back(want);
               points++;
            end
            default: begin
               ignored++;
            end
         endcase
      endfunction

      task check_response(word_type r0, word_type r1, word_type r2, word_type r3,
                          index_type column, logic overflow);
         product_beat_type want;
         word_type         got [4];
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result beat", r0, '0);
            return;
         end
         want = expected_q.pop_front();
         got = '{r0, r1, r2, r3};
         for (int r = 0; r < 4; r++)
            if (got[r] !== want.res[r])
               report_mismatch($sformatf("res%0d", r), got[r], want.res[r]);
         if (column !== want.column)
            report_mismatch("out_column", 32'(column), 32'(want.column));
         if (overflow !== want.overflow)
            report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
      endtask
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   logic [1:0] req_cmd = '0;
   index_type req_column_index = '0;
   word_type  req_elem0 = '0;
   word_type  req_elem1 = '0;
   word_type  req_elem2 = '0;
   word_type  req_elem3 = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   word_type  rsp_res0;
   word_type  rsp_res1;
   word_type  rsp_res2;
   word_type  rsp_res3;
   index_type rsp_out_column;
   logic      rsp_overflow;

   int        send_idle_pct = 0;
   int        stall_pct = 0;
   logic      hold_request = 1'b0;
   logic      stall_hold = 1'b0;
   int        cycle_count = 0;

   column_product_scoreboard sb = new();

   matrix4_column_product dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_column_index (req_column_index),
      .req_elem0        (req_elem0),
      .req_elem1        (req_elem1),
      .req_elem2        (req_elem2),
      .req_elem3        (req_elem3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_res0         (rsp_res0),
      .rsp_res1         (rsp_res1),
      .rsp_res2         (rsp_res2),
      .rsp_res3         (rsp_res3),
      .rsp_out_column   (rsp_out_column),
      .rsp_overflow     (rsp_overflow)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The long hold-off runs on its own count so the sender keeps offering beats.
   initial begin
      wait (hold_request);
      @(posedge clock);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      stall_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_res0, rsp_res1, rsp_res2, rsp_res3, rsp_out_column,
                           rsp_overflow);
      rsp_ready <= !stall_hold && ($urandom_range(99) >= stall_pct);
   end

   function automatic word_type rand_word();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2, 3, 4: return word_type'($urandom);
         default: return word_type'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   task automatic send_beat(logic [1:0] cmd, index_type col, word_type e0, word_type e1,
                            word_type e2, word_type e3);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_column_index <= col;
      req_elem0 <= e0;
      req_elem1 <= e1;
      req_elem2 <= e2;
      req_elem3 <= e3;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, col, e0, e1, e2, e3);
   endtask

   task automatic run_phase(int beats, int idle, int stall, bit with_hold);
      int         counted;
      int         pick;
      logic [1:0] cmd;
      counted = 0;
      send_idle_pct = idle;
      stall_pct <= stall;
      while (counted < beats) begin
         pick = $urandom_range(99);
         if (pick < 20) cmd = CMD_LOAD;
         else if (pick < 60) cmd = CMD_MULTIPLY;
         else if (pick < 95) cmd = CMD_POINT;
         else cmd = CMD_UNUSED;
         send_beat(cmd, index_type'($urandom_range(3)), rand_word(), rand_word(),
                   rand_word(), rand_word());
         if (cmd != CMD_UNUSED) counted++;
         if (with_hold && counted == 10) hold_request = 1'b1;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every column is loaded before anything reads the matrix.
      send_beat(CMD_LOAD, 2'd0, WORD_ONE, '0, '0, '0);
      send_beat(CMD_LOAD, 2'd1, '0, WORD_ONE, '0, '0);
      send_beat(CMD_LOAD, 2'd2, '0, '0, WORD_ONE, '0);
      send_beat(CMD_LOAD, 2'd3, '0, '0, '0, WORD_ONE);
      send_beat(CMD_MULTIPLY, 2'd0, WORD_MAX, WORD_MIN, -32'sd1, 32'sd1);
      send_beat(CMD_POINT, 2'd3, 32'sh0001_8000, -32'sh0000_8000, WORD_MAX, WORD_MIN);
      send_beat(CMD_UNUSED, 2'd2, '1, '1, '1, '1);
      send_beat(CMD_MULTIPLY, 2'd1, -32'sd1, -32'sd3, 32'sd5, WORD_ONE);
      send_beat(CMD_LOAD, 2'd0, WORD_ONE, -32'sh0002_0000, 32'sh0000_4000, 32'sh0005_0000);
      send_beat(CMD_LOAD, 2'd1, 32'sd1, WORD_ONE, -32'sd7, -32'sh0003_0000);
      send_beat(CMD_LOAD, 2'd2, -32'sd1, 32'sd2, WORD_ONE, WORD_MIN);
      send_beat(CMD_POINT, 2'd1, -32'sd1, 32'sd3, -32'sd5, '0);
      send_beat(CMD_MULTIPLY, 2'd2, -32'sd1, 32'sd1, -32'sd1, -32'sd1);
      for (int c = 0; c < 4; c++) send_beat(CMD_LOAD, index_type'(c), WORD_MAX, WORD_MAX,
                                            WORD_MAX, WORD_MAX);
      send_beat(CMD_MULTIPLY, 2'd3, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_beat(CMD_MULTIPLY, 2'd2, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_beat(CMD_POINT, 2'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX);
      for (int c = 0; c < 4; c++) send_beat(CMD_LOAD, index_type'(c), WORD_MIN, WORD_MIN,
                                            WORD_MIN, WORD_MIN);
      send_beat(CMD_MULTIPLY, 2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_beat(CMD_POINT, 2'd2, WORD_MAX, WORD_MAX, WORD_MAX, '0);

      run_phase(100, 0, 0, 1'b1);
      run_phase(100, 76, 0, 1'b0);
      run_phase(100, 0, 76, 1'b0);
      run_phase(100, 33, 33, 1'b0);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("results still pending", sb.pending(), '0);

      $display("Covered %0d column loads, %0d column products, %0d point transforms",
               sb.loads, sb.products, sb.points);
      $display("and %0d unused-command beats, over %0d clock cycles.", sb.ignored,
               cycle_count);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
